// ===== rtl/dprm_pkg.sv =====
// Shared constants and codes for the dirty-page range marker.
package dprm_pkg;

	localparam int LOG_WORDS_DEF  = 1024;
	localparam int PAGE_SHIFT_DEF = 12;

	localparam int WORD_BITS  = 64;
	localparam int BIT_IDX_W  = 6;
	localparam int ADDR_W     = 64;
	localparam int LEN_W      = 32;
	localparam int IDX_W      = 10;
	localparam int CFG_DATA_W = 14;
	localparam int STATUS_W   = 2;

	typedef enum logic [STATUS_W-1:0] {
		ST_OK    = 2'd0,
		ST_CLAMP = 2'd1,
		ST_DROP  = 2'd2,
		ST_OFF   = 2'd3
	} status_t;

	typedef enum logic {
		OP_MARK = 1'b0,
		OP_READ = 1'b1
	} op_t;

	typedef enum logic {
		CFG_LOG_ENABLED = 1'b0,
		CFG_LOG_BYTES   = 1'b1
	} cfg_idx_t;

endpackage

// ===== rtl/dprm_bitmap_ram.sv =====
// Bitmap word store: one write port, one read port with registered data.
module dprm_bitmap_ram
	import dprm_pkg::*;
#(
	parameter int DEPTH = LOG_WORDS_DEF,
	parameter int AW    = 10
) (
	input  logic                 clk,
	input  logic                 we,
	input  logic [AW-1:0]        waddr,
	input  logic [WORD_BITS-1:0] wdata,
	input  logic [AW-1:0]        raddr,
	output logic [WORD_BITS-1:0] rdata
);

	logic [WORD_BITS-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		rdata <= mem[raddr];
	end

endmodule

// ===== rtl/dprm_word_unit.sv =====
// Per-word mask unit: builds the OR mask for the current bitmap word.
module dprm_word_unit
	import dprm_pkg::*;
#(
	parameter int AW   = 10,
	parameter int PG_W = 16
) (
	input  logic [AW-1:0]        cur_w,
	input  logic [PG_W-1:0]      first_page,
	input  logic [PG_W-1:0]      stop_page,
	output logic [WORD_BITS-1:0] mask,
	output logic                 is_last,
	output logic [AW-1:0]        next_w
);

	logic                 is_first;
	logic [BIT_IDX_W-1:0] lo;
	logic [BIT_IDX_W-1:0] hi;
	logic [BIT_IDX_W-1:0] hi_inv;

	always_comb begin
		is_first = (cur_w == first_page[PG_W-1:BIT_IDX_W]);
		is_last  = (cur_w == stop_page[PG_W-1:BIT_IDX_W]);
		lo       = is_first ? first_page[BIT_IDX_W-1:0] : '0;
		hi       = is_last ? stop_page[BIT_IDX_W-1:0] : '1;
		hi_inv   = ~hi;  // 63 - hi
		mask     = ({WORD_BITS{1'b1}} << lo) & ({WORD_BITS{1'b1}} >> hi_inv);
		next_w   = cur_w + AW'(1);
	end

endmodule

// ===== rtl/dirty_page_range_marker_unit.sv =====
// Dirty-page range marker: top level with sequencer, config and result registers.
// Steps (start transfer to done strobe): mark with logging off or zero length ends in S_IDLE;
//   read goes S_RDOUT; dropped mark S_CALC, S_CHECK; mark S_CALC, S_CHECK, S_RD, then S_WR,
//   one bitmap word per cycle through the mask unit and the bitmap store's write and read ports.
// One item at a time: busy until done (never raised for marks ended in idle); results cannot stall.
// Reset: async, active low; then a clearing pass (S_CLEAR) zeroes every bitmap word, busy high.
module dirty_page_range_marker_unit
	import dprm_pkg::*;
#(
	parameter int LOG_WORDS  = LOG_WORDS_DEF,
	parameter int PAGE_SHIFT = PAGE_SHIFT_DEF
) (
	input  logic                  clk,
	input  logic                  arst_n,
	// command side
	input  logic                  start,
	output logic                  busy,
	input  logic                  op,
	input  logic [ADDR_W-1:0]     guest_addr,
	input  logic [LEN_W-1:0]      byte_len,
	input  logic [IDX_W-1:0]      word_index,
	// result side
	output logic                  done,
	output logic [STATUS_W-1:0]   status,
	output logic [WORD_BITS-1:0]  read_data,
	// register write channel
	input  logic                  cfg_valid,
	output logic                  cfg_ready,
	input  logic                  cfg_index,
	input  logic [CFG_DATA_W-1:0] cfg_data
);

	// bitmap word address width, page number width inside the log
	localparam int AW    = (LOG_WORDS > 1) ? $clog2(LOG_WORDS) : 1;
	localparam int PG_W  = AW + BIT_IDX_W;
	localparam int CAP   = LOG_WORDS * WORD_BITS;
	localparam int CAP_W = $clog2(CAP + 1);
	localparam int LIM_W = (CAP_W > 17) ? CAP_W : 17;
	localparam int IXW   = (AW > IDX_W) ? AW : IDX_W;
	localparam int SUM_W = ADDR_W + 1;

	typedef enum logic [2:0] {
		S_CLEAR,
		S_IDLE,
		S_CALC,
		S_CHECK,
		S_RD,
		S_WR,
		S_RDOUT
	} state_t;

	state_t state_q;

	// configuration registers
	logic                  log_enabled_q;
	logic [CFG_DATA_W-1:0] log_bytes_q;

	// per-item working registers
	logic [ADDR_W-1:0]    addr_q;
	logic [LEN_W-1:0]     len_m1_q;
	logic [SUM_W-1:0]     end_q;       // addr + len - 1 with carry out
	logic [LIM_W-1:0]     lim_q;       // saturated page limit
	logic [PG_W-1:0]      first_page_q;
	logic [PG_W-1:0]      end_page_q;  // last page marked (after clamp)
	logic [AW-1:0]        w_q;         // current bitmap word
	logic [AW-1:0]        clr_cnt_q;
	logic                 idx_ok_q;
	logic [STATUS_W-1:0]  mark_st_q;

	// result registers
	logic                 done_q;
	logic [STATUS_W-1:0]  status_q;
	logic [WORD_BITS-1:0] read_data_q;

	// memory and mask unit hookup
	logic                 ram_we;
	logic [AW-1:0]        ram_waddr;
	logic [WORD_BITS-1:0] ram_wdata;
	logic [AW-1:0]        ram_raddr;
	logic [WORD_BITS-1:0] ram_rdata;
	logic [WORD_BITS-1:0] mask;
	logic                 is_last;
	logic [AW-1:0]        next_w;

	// combinational helpers
	logic                 accept;
	logic [IXW-1:0]       idx_ext;
	logic                 idx_in_range;
	logic [LIM_W-1:0]     lb_pages;
	logic [LIM_W-1:0]     lim_next;
	logic [LIM_W-1:0]     lim_m1;
	logic [ADDR_W-1:0]    first_full;
	logic [ADDR_W-1:0]    last_full;
	logic                 last_ge;
	logic                 first_ge;
	logic [PG_W-1:0]      last_sel;

	assign busy      = (state_q != S_IDLE);
	assign accept    = start && !busy;
	assign cfg_ready = 1'b1;

	assign done      = done_q;
	assign status    = status_q;
	assign read_data = read_data_q;

	always_comb begin
		idx_ext      = IXW'(word_index);
		idx_in_range = (32'(word_index) < 32'(LOG_WORDS));

		// log_bytes * 8 pages, capped at the store size
		lb_pages = LIM_W'({log_bytes_q, 3'b000});
		lim_next = (lb_pages > LIM_W'(CAP)) ? LIM_W'(CAP) : lb_pages;
		lim_m1   = lim_q - LIM_W'(1);

		// range check against the page limit
		first_full = addr_q >> PAGE_SHIFT;
		last_full  = end_q[ADDR_W-1:0] >> PAGE_SHIFT;
		last_ge    = end_q[ADDR_W] || (last_full >= ADDR_W'(lim_q));
		first_ge   = (first_full >= ADDR_W'(lim_q));
		last_sel   = last_ge ? PG_W'(lim_m1) : last_full[PG_W-1:0];

		// bitmap store ports
		ram_we    = (state_q == S_CLEAR) || (state_q == S_WR);
		ram_waddr = (state_q == S_CLEAR) ? clr_cnt_q : w_q;
		ram_wdata = (state_q == S_CLEAR) ? '0 : (ram_rdata | mask);
		case (state_q)
			S_IDLE:  ram_raddr = idx_ext[AW-1:0];
			S_WR:    ram_raddr = next_w;   // prefetch the next word
			default: ram_raddr = w_q;
		endcase
	end

	dprm_bitmap_ram #(
		.DEPTH (LOG_WORDS),
		.AW    (AW)
	) u_ram (
		.clk   (clk),
		.we    (ram_we),
		.waddr (ram_waddr),
		.wdata (ram_wdata),
		.raddr (ram_raddr),
		.rdata (ram_rdata)
	);

	dprm_word_unit #(
		.AW   (AW),
		.PG_W (PG_W)
	) u_word (
		.cur_w      (w_q),
		.first_page (first_page_q),
		.stop_page  (end_page_q),
		.mask       (mask),
		.is_last    (is_last),
		.next_w     (next_w)
	);

	// configuration writes
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			log_enabled_q <= 1'b0;
			log_bytes_q   <= '0;
		end else if (cfg_valid && cfg_ready) begin
			case (cfg_index)
				CFG_LOG_ENABLED: log_enabled_q <= cfg_data[0];
				CFG_LOG_BYTES:   log_bytes_q   <= cfg_data;
				default:         log_bytes_q   <= log_bytes_q;
			endcase
		end
	end

	// sequencer and result registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_CLEAR;
			clr_cnt_q   <= '0;
			done_q      <= 1'b0;
			status_q    <= ST_OK;
			read_data_q <= '0;
		end else begin
			done_q <= 1'b0;
			case (state_q)
				S_CLEAR: begin
					clr_cnt_q <= clr_cnt_q + AW'(1);
					if (clr_cnt_q == AW'(LOG_WORDS - 1)) begin
						state_q <= S_IDLE;
					end
				end
				S_IDLE: begin
					if (accept) begin
						if (op == OP_READ) begin
							state_q <= S_RDOUT;
						end else if (!log_enabled_q) begin
							done_q      <= 1'b1;
							status_q    <= ST_OFF;
							read_data_q <= '0;
						end else if (byte_len == '0) begin
							done_q      <= 1'b1;
							status_q    <= ST_OK;
							read_data_q <= '0;
						end else begin
							state_q <= S_CALC;
						end
					end
				end
				S_CALC: begin
					state_q <= S_CHECK;
				end
				S_CHECK: begin
					if (last_ge && first_ge) begin
						// range starts past the log end
						done_q      <= 1'b1;
						status_q    <= ST_DROP;
						read_data_q <= '0;
						state_q     <= S_IDLE;
					end else begin
						state_q <= S_RD;
					end
				end
				S_RD: begin
					state_q <= S_WR;
				end
				S_WR: begin
					if (is_last) begin
						done_q      <= 1'b1;
						status_q    <= mark_st_q;
						read_data_q <= '0;
						state_q     <= S_IDLE;
					end
				end
				S_RDOUT: begin
					done_q      <= 1'b1;
					status_q    <= ST_OK;
					read_data_q <= idx_ok_q ? ram_rdata : '0;
					state_q     <= S_IDLE;
				end
				default: begin
					state_q <= S_IDLE;
				end
			endcase
		end
	end

	// payload registers, no reset needed
	always_ff @(posedge clk) begin
		if (accept) begin
			addr_q   <= guest_addr;
			len_m1_q <= byte_len - LEN_W'(1);
			idx_ok_q <= idx_in_range;
		end
		if (state_q == S_CALC) begin
			end_q <= {1'b0, addr_q} + SUM_W'(len_m1_q);
			lim_q <= lim_next;
		end
		if (state_q == S_CHECK) begin
			first_page_q <= first_full[PG_W-1:0];
			end_page_q   <= last_sel;
			w_q          <= first_full[PG_W-1:BIT_IDX_W];
			mark_st_q    <= last_ge ? ST_CLAMP : ST_OK;
		end
		if (state_q == S_WR) begin
			w_q <= next_w;
		end
	end

endmodule
